// File: src/ratiometric_clamp_detector_macros.svh
// Assertion helpers used by the checker file.
`ifndef RATIOMETRIC_CLAMP_DETECTOR_MACROS_SVH
`define RATIOMETRIC_CLAMP_DETECTOR_MACROS_SVH

// Clocked property, quiet while reset is asserted.
`define RCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen on a clock edge outside reset.
`define RCD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: src/rcd_pkg.sv
package rcd_pkg;

  // Register indexes on the write port
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_REFERENCE_MV   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CLAMP_LEVEL_MV = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_HYSTERESIS_MV  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_BLANK_EVENTS   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_REF_SHIFT      = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SENSE_SHIFT    = 3'd5;

  // Reset values
  localparam logic [15:0] RstReferenceMv  = 16'd2480;
  localparam logic [15:0] RstClampLevelMv = 16'd2000;
  localparam logic [15:0] RstHysteresisMv = 16'd50;
  localparam logic [7:0]  RstBlankEvents  = 8'd32;
  localparam logic [3:0]  RstRefShift     = 4'd8;
  localparam logic [3:0]  RstSenseShift   = 4'd5;
  localparam logic [11:0] RstRefAvgCode   = 12'd880;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_LOAD,
    ST_DIV,
    ST_FILT,
    ST_DONE
  } rcd_state_e;

  typedef struct packed {
    logic capture;  // latch the input item
    logic prep;     // blanking, reference average, product
    logic load;     // divider setup and saturation check
    logic step;     // one quotient bit
    logic filt;     // sense average
    logic finish;   // comparator, result register
  } rcd_cmd_t;

  typedef struct packed {
    logic out_free;  // result register may be loaded this cycle
  } rcd_sts_t;

endpackage

// File: src/rcd_ctrl.sv
module rcd_ctrl #(
  parameter int unsigned FRACTION_BITS = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rcd_pkg::rcd_sts_t sts_i,
  output rcd_pkg::rcd_cmd_t cmd_o
);
  import rcd_pkg::*;

  localparam int unsigned QuotBits = 16 + FRACTION_BITS;
  localparam int unsigned CntW     = $clog2(QuotBits);

  rcd_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic div_last;

  assign div_last = (cnt_q == CntW'(QuotBits - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_PREP;
      ST_PREP: state_d = ST_LOAD;
      ST_LOAD: begin
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (div_last) state_d = ST_FILT;
      end
      ST_FILT: state_d = ST_DONE;
      ST_DONE: if (sts_i.out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_PREP: cmd_o.prep = 1'b1;
      ST_LOAD: cmd_o.load = 1'b1;
      ST_DIV:  cmd_o.step = 1'b1;
      ST_FILT: cmd_o.filt = 1'b1;
      ST_DONE: cmd_o.finish = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// File: src/rcd_datapath.sv
module rcd_datapath #(
  parameter int unsigned FRACTION_BITS = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rcd_pkg::CfgIdxW-1:0]     cfg_addr_i,
  input  logic [15:0]                     cfg_wdata_i,
  input  logic [11:0]                     sense_sample_i,
  input  logic [11:0]                     ref_sample_i,
  input  rcd_pkg::rcd_cmd_t               cmd_i,
  output rcd_pkg::rcd_sts_t               sts_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [31:0]                     out_data_o
);
  import rcd_pkg::*;

  localparam int unsigned F        = FRACTION_BITS;
  localparam int unsigned RefW     = 12 + F;      // 12.F reference average
  localparam int unsigned LvlW     = 16 + F;      // 16.F level and sense average
  localparam int unsigned NumW     = 28;          // sample * reference_mv
  localparam int unsigned DvdW     = NumW + 2 * F;
  localparam int unsigned QuotBits = 16 + F;

  // configuration
  logic [15:0] ref_mv_q, clamp_mv_q, hyst_mv_q;
  logic [7:0]  blank_ev_q;
  logic [3:0]  ref_sh_q, sen_sh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_mv_q   <= RstReferenceMv;
      clamp_mv_q <= RstClampLevelMv;
      hyst_mv_q  <= RstHysteresisMv;
      blank_ev_q <= RstBlankEvents;
      ref_sh_q   <= RstRefShift;
      sen_sh_q   <= RstSenseShift;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_REFERENCE_MV:   ref_mv_q   <= cfg_wdata_i;
        CFG_CLAMP_LEVEL_MV: clamp_mv_q <= cfg_wdata_i;
        CFG_HYSTERESIS_MV:  hyst_mv_q  <= cfg_wdata_i;
        CFG_BLANK_EVENTS:   blank_ev_q <= cfg_wdata_i[7:0];
        CFG_REF_SHIFT:      ref_sh_q   <= cfg_wdata_i[3:0];
        CFG_SENSE_SHIFT:    sen_sh_q   <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // item payload, product and divider (no reset needed)
  logic [11:0]         sense_q, refc_q;
  logic [NumW-1:0]     num_q;
  logic [RefW-1:0]     rem_q;
  logic [QuotBits-1:0] dvd_q, quot_q;
  logic                sat_q;
  logic [31:0]         out_data_q;

  // filter state and control
  logic [7:0]      blank_cnt_q;
  logic [RefW-1:0] ref_avg_q;
  logic [LvlW-1:0] sense_avg_q;
  logic            flag_q;
  logic            out_valid_q;

  // reference average step, floor of a signed shift
  logic [RefW-1:0]        ref_x;
  logic signed [RefW:0]   ref_diff, ref_inc, ref_sum;
  assign ref_x    = {refc_q, {F{1'b0}}};
  assign ref_diff = $signed({1'b0, ref_x}) - $signed({1'b0, ref_avg_q});
  assign ref_inc  = ref_diff >>> ref_sh_q;
  assign ref_sum  = $signed({1'b0, ref_avg_q}) + ref_inc;

  // divider setup: top of the dividend must stay below the divisor
  logic [DvdW-1:0] dividend;
  logic [RefW-1:0] rem_init;
  assign dividend = {num_q, {(2 * F){1'b0}}};
  assign rem_init = dividend[DvdW-1:QuotBits];

  // restoring step
  logic [RefW:0] rem_sh, rem_sub;
  logic          rem_ge;
  assign rem_sh  = {rem_q, dvd_q[QuotBits-1]};
  assign rem_ge  = rem_sh >= {1'b0, ref_avg_q};
  assign rem_sub = rem_sh - {1'b0, ref_avg_q};

  // sense average step
  logic [LvlW-1:0]      level;
  logic signed [LvlW:0] sen_diff, sen_inc, sen_sum;
  assign level    = sat_q ? {LvlW{1'b1}} : quot_q;
  assign sen_diff = $signed({1'b0, level}) - $signed({1'b0, sense_avg_q});
  assign sen_inc  = sen_diff >>> sen_sh_q;
  assign sen_sum  = $signed({1'b0, sense_avg_q}) + sen_inc;

  // hysteresis comparator
  logic [16:0]     band_hi;
  logic [LvlW:0]   upper;
  logic [LvlW-1:0] lower;
  logic            above, below, blank_done, flag_d;
  assign band_hi    = {1'b0, clamp_mv_q} + {1'b0, hyst_mv_q};
  assign upper      = {band_hi, {F{1'b0}}};
  assign lower      = (clamp_mv_q > hyst_mv_q) ? {clamp_mv_q - hyst_mv_q, {F{1'b0}}} : '0;
  assign above      = {1'b0, sense_avg_q} > upper;
  assign below      = sense_avg_q < lower;
  assign blank_done = blank_cnt_q >= blank_ev_q;
  assign flag_d     = flag_q ? !below : (above && blank_done);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sense_q <= sense_sample_i;
      refc_q  <= ref_sample_i;
    end
    if (cmd_i.prep) begin
      num_q <= NumW'(sense_q) * NumW'(ref_mv_q);
    end
    if (cmd_i.load) begin
      rem_q  <= rem_init;
      dvd_q  <= dividend[QuotBits-1:0];
      quot_q <= '0;
      sat_q  <= (ref_avg_q == '0) || (rem_init >= ref_avg_q);
    end else if (cmd_i.step) begin
      rem_q  <= rem_ge ? rem_sub[RefW-1:0] : rem_sh[RefW-1:0];
      dvd_q  <= {dvd_q[QuotBits-2:0], 1'b0};
      quot_q <= {quot_q[QuotBits-2:0], rem_ge};
    end
    if (cmd_i.finish) begin
      out_data_q <= 32'({ref_avg_q[RefW-1:F], sense_avg_q[LvlW-1:F], flag_d});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blank_cnt_q <= '0;
      ref_avg_q   <= {RstRefAvgCode, {F{1'b0}}};
      sense_avg_q <= '0;
      flag_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.prep) begin
        if (blank_cnt_q < blank_ev_q) blank_cnt_q <= blank_cnt_q + 8'd1;
        ref_avg_q <= ref_sum[RefW-1:0];
      end
      if (cmd_i.filt) sense_avg_q <= sen_sum[LvlW-1:0];
      if (cmd_i.finish) begin
        flag_q      <= flag_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;

endmodule

// File: src/ratiometric_clamp_detector.sv
// Channel | Dir | Bits of tdata, lowest first
// s_axis  | in  | sense_sample[11:0], ref_sample[23:12]
// m_axis  | out | clamp_active[0], sense_avg_mv[16:1], ref_avg_code[28:17], zero[31:29]
// cfg     | in  | cfg_we_i, cfg_addr_i (register index), cfg_wdata_i
//
// The divider retires one quotient bit per cycle, 16 + FRACTION_BITS bits in all.
// One item is in flight at a time; s_axis_tready is high only while idle.
// A result waiting on m_axis does not block the next accept; a finished item
// holds in its last step until the result register frees up.
// Reset: ref average 880.0, sense average 0, blanking count 0, clamp flag set.
module ratiometric_clamp_detector #(
  parameter int unsigned FRACTION_BITS = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration writes
  input  logic                        cfg_we_i,
  input  logic [rcd_pkg::CfgIdxW-1:0] cfg_addr_i,
  input  logic [15:0]                 cfg_wdata_i,
  // sample pairs
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [23:0]                 s_axis_tdata,  // sense_sample, ref_sample
  // results
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [31:0]                 m_axis_tdata   // clamp_active, sense_avg_mv, ref_avg_code
);
  import rcd_pkg::*;

  rcd_cmd_t cmd;
  rcd_sts_t sts;

  // sequencer: accept, prep, divider setup, divide, filter, result
  rcd_ctrl #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // filters, divider, comparator and result register
  rcd_datapath #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .sense_sample_i (s_axis_tdata[11:0]),
    .ref_sample_i   (s_axis_tdata[23:12]),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_data_o     (m_axis_tdata)
  );

endmodule

// File: src/rcd_checker.sv
`include "ratiometric_clamp_detector_macros.svh"

module rcd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  logic s_fire;
  assign s_fire = s_axis_tvalid && s_axis_tready;

  // one item at a time: no second accept right behind the first
  `RCD_ASSERT(a_one_in_flight, s_fire |=> !s_axis_tready ##1 !s_axis_tready, "accept while busy")

  // a new result only shows up after a busy cycle
  `RCD_ASSERT(a_result_after_work, $rose(m_axis_tvalid) |-> !$past(s_axis_tready), "result from idle")

  // stalled result holds
  `RCD_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result dropped")

  // padding above ref_avg_code stays zero
  `RCD_NEVER(a_pad_zero, m_axis_tvalid && (m_axis_tdata[31:29] != 3'b000), "pad bits set")

endmodule

bind ratiometric_clamp_detector rcd_checker u_rcd_checker (.*);
